>>> design/wchb_pkg.sv
// Package for the write-combining hash buffer.
// Holds the field widths, the operation and result codes, and the item and entry types.
// No dependencies.
package wchb_pkg;

    localparam int OBJ_W   = 24;
    localparam int ATTR_W  = 20;
    localparam int VALUE_W = 32;

    // Hash: object ^ (attr << 7) ^ (attr >> 3); the widest term is attr << 7.
    localparam int HASH_SHL   = 7;
    localparam int HASH_SHR   = 3;
    localparam int HASH_W     = ATTR_W + HASH_SHL;
    // The modulo unit folds CHUNK_W hash bits into the remainder per cycle.
    localparam int CHUNK_W    = 7;
    localparam int HASH_STEPS = (HASH_W + CHUNK_W - 1) / CHUNK_W;
    localparam int SH_W       = CHUNK_W * HASH_STEPS;
    localparam int STEP_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_PUT    = 2'd1,
        OP_DELETE = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_LOOKUP     = 2'd0,
        KIND_DONE       = 2'd1,
        KIND_FLUSHED    = 2'd2,
        KIND_FLUSH_DONE = 2'd3
    } kind_t;

    typedef struct packed {
        op_t                 op;
        logic [OBJ_W-1:0]    key_object;
        logic [ATTR_W-1:0]   key_attr;
        logic [VALUE_W-1:0]  data_value;
    } req_t;

    typedef struct packed {
        kind_t               kind;
        logic                hit;
        logic                is_deleted;
        logic [VALUE_W-1:0]  out_value;
        logic [OBJ_W-1:0]    out_object;
        logic [ATTR_W-1:0]   out_attr;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic [OBJ_W-1:0]    object;
        logic [ATTR_W-1:0]   attr;
        logic                deleted;
        logic [VALUE_W-1:0]  value;
    } entry_t;

endpackage

>>> design/wchb_if.sv
// Handshake interfaces for the request and response channels of the hash buffer.
// Depends on wchb_pkg for field widths and code types.
interface wchb_req_if;
    logic                         valid;
    logic                         ready;
    wchb_pkg::op_t                op;
    logic [wchb_pkg::OBJ_W-1:0]   key_object;
    logic [wchb_pkg::ATTR_W-1:0]  key_attr;
    logic [wchb_pkg::VALUE_W-1:0] data_value;

    modport source (output valid, output op, output key_object, output key_attr,
                    output data_value, input ready);
    modport sink   (input valid, input op, input key_object, input key_attr,
                    input data_value, output ready);
endinterface

interface wchb_rsp_if;
    logic                         valid;
    logic                         ready;
    wchb_pkg::kind_t              kind;
    logic                         hit;
    logic                         is_deleted;
    logic [wchb_pkg::VALUE_W-1:0] out_value;
    logic [wchb_pkg::OBJ_W-1:0]   out_object;
    logic [wchb_pkg::ATTR_W-1:0]  out_attr;
    logic                         last;

    modport source (output valid, output kind, output hit, output is_deleted,
                    output out_value, output out_object, output out_attr,
                    output last, input ready);
    modport sink   (input valid, input kind, input hit, input is_deleted,
                    input out_value, input out_object, input out_attr,
                    input last, output ready);
endinterface

>>> design/wchb_hash.sv
// Iterative home-slot unit: hashes the key and reduces it modulo the capacity,
// several bits per cycle. Depends on wchb_pkg.
module wchb_hash #(
    parameter int CAPACITY = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wchb_pkg::OBJ_W-1:0]    key_object,
    input  logic [wchb_pkg::ATTR_W-1:0]   key_attr,
    output logic                          done,
    output logic [$clog2(CAPACITY)-1:0]   slot
);

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW:0] CAP_V = (IW + 1)'(CAPACITY);

    logic                          busy_reg, busy_next;
    logic [wchb_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [wchb_pkg::SH_W-1:0]     sh_reg, sh_next;
    logic [IW-1:0]                 rem_reg, rem_next;
    logic [wchb_pkg::HASH_W-1:0]   hash;
    logic [IW:0]                   acc;

    assign hash = wchb_pkg::HASH_W'(key_object)
                ^ (wchb_pkg::HASH_W'(key_attr) << wchb_pkg::HASH_SHL)
                ^ wchb_pkg::HASH_W'(key_attr >> wchb_pkg::HASH_SHR);

    // Restoring reduction: per hash bit, shift it into the remainder and subtract the capacity at most once.
    always_comb
    begin
        acc = {1'b0, rem_reg};
        for (int k = 0; k < wchb_pkg::CHUNK_W; k++)
        begin
            acc = {acc[IW-1:0], sh_reg[wchb_pkg::SH_W-1-k]};
            if (acc >= CAP_V)
            begin
                acc = acc - CAP_V;
            end
        end
        rem_next = acc[IW-1:0];
    end

    assign done = busy_reg && (cnt_reg == wchb_pkg::STEP_W'(wchb_pkg::HASH_STEPS - 1));
    assign slot = rem_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
        sh_next = start ? wchb_pkg::SH_W'(hash) : (sh_reg << wchb_pkg::CHUNK_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= start ? '0 : rem_next;
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("hash unit restarted while busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg)
        else $error("hash unit still busy after done");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((IW + 1)'(slot) < CAP_V))
        else $error("home slot beyond capacity");
`endif

endmodule

>>> design/write_combining_hash_buffer.sv
// A lookup or put is answered after the iterative hashing, one memory read per probed slot
// from the home slot on, and the output register. A flush sweeps every slot in turn.
// Requests are taken one at a time: a new one is accepted only in the idle state. The
// modulo unit and the entry memory, one write and one read port probing one slot per cycle,
// set the pace, plus output stalls. Reset clears the slot valid bits and the control
// state at once.
module write_combining_hash_buffer #(
    parameter int CAPACITY = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    wchb_req_if.sink         req,
    wchb_rsp_if.source       rsp
);

    // Slot index width. The table is one synchronous memory of entries plus a
    // flip-flop valid bit per slot, so a reset empties the table immediately.
    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FLUSH,
        S_FDONE
    } state_t;

    state_t                 state_reg, state_next;
    wchb_pkg::req_t         req_reg, req_next;
    logic [IW-1:0]          home_reg, home_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [CAPACITY-1:0]    used_reg, used_next;
    logic                   ovalid_reg, ovalid_next;
    wchb_pkg::rsp_t         out_reg, out_next;

    wchb_pkg::entry_t       mem [CAPACITY];
    wchb_pkg::entry_t       rd_data_reg;
    wchb_pkg::entry_t       wr_entry;
    logic                   mem_we;

    logic                   hash_start;
    logic                   hash_done;
    logic [IW-1:0]          hash_slot;

    logic                   out_free;
    logic                   out_load;
    logic                   slot_used;
    logic                   key_match;
    logic [IW-1:0]          idx_inc;

    wchb_hash #(
        .CAPACITY (CAPACITY)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (hash_start),
        .key_object (req.key_object),
        .key_attr   (req.key_attr),
        .done       (hash_done),
        .slot       (hash_slot)
    );

    // The output register may be refilled in the same cycle its item leaves.
    assign out_free  = !ovalid_reg || rsp.ready;
    assign slot_used = used_reg[idx_reg];
    assign key_match = (rd_data_reg.object == req_reg.key_object)
                    && (rd_data_reg.attr == req_reg.key_attr);
    assign idx_inc   = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;

    // Entry written by a put or delete: the key, the marker, and the value or zero.
    always_comb
    begin
        wr_entry.object  = req_reg.key_object;
        wr_entry.attr    = req_reg.key_attr;
        wr_entry.deleted = (req_reg.op == wchb_pkg::OP_DELETE);
        wr_entry.value   = (req_reg.op == wchb_pkg::OP_PUT) ? req_reg.data_value : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        home_next  = home_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        out_next   = out_reg;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        hash_start = 1'b0;
        req.ready  = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next.op         = req.op;
                    req_next.key_object = req.key_object;
                    req_next.key_attr   = req.key_attr;
                    req_next.data_value = req.data_value;
                    if (req.op == wchb_pkg::OP_FLUSH)
                    begin
                        // A flush needs no hash; start the sweep at slot zero.
                        idx_next   = '0;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    home_next  = hash_slot;
                    idx_next   = hash_slot;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // rd_data_reg holds the entry of slot idx_reg in this state.
                if (!slot_used || key_match)
                begin
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_next        = '0;
                        out_next.hit    = slot_used;
                        out_next.last   = 1'b1;
                        if (req_reg.op == wchb_pkg::OP_LOOKUP)
                        begin
                            out_next.kind       = wchb_pkg::KIND_LOOKUP;
                            out_next.is_deleted = slot_used && rd_data_reg.deleted;
                            if (slot_used && !rd_data_reg.deleted)
                            begin
                                out_next.out_value = rd_data_reg.value;
                            end
                        end
                        else
                        begin
                            out_next.kind       = wchb_pkg::KIND_DONE;
                            out_next.is_deleted = (req_reg.op == wchb_pkg::OP_DELETE);
                            mem_we              = 1'b1;
                            used_next[idx_reg]  = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (idx_inc == home_reg)
                begin
                    // Every slot is taken and none holds the key.
                    if (req_reg.op == wchb_pkg::OP_LOOKUP)
                    begin
                        if (out_free)
                        begin
                            out_load      = 1'b1;
                            out_next      = '0;
                            out_next.kind = wchb_pkg::KIND_LOOKUP;
                            out_next.last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_FLUSH:
            begin
                if (!slot_used || out_free)
                begin
                    if (slot_used)
                    begin
                        out_load            = 1'b1;
                        out_next            = '0;
                        out_next.kind       = wchb_pkg::KIND_FLUSHED;
                        out_next.is_deleted = rd_data_reg.deleted;
                        out_next.out_value  = rd_data_reg.deleted ? '0 : rd_data_reg.value;
                        out_next.out_object = rd_data_reg.object;
                        out_next.out_attr   = rd_data_reg.attr;
                        used_next[idx_reg]  = 1'b0;
                    end
                    if (idx_reg == LAST_SLOT)
                    begin
                        if (req_reg.op == wchb_pkg::OP_FLUSH)
                        begin
                            state_next = S_FDONE;
                        end
                        else
                        begin
                            // Table is empty now: the home slot takes the key.
                            idx_next   = home_reg;
                            state_next = S_PROBE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_FDONE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_next      = '0;
                    out_next.kind = wchb_pkg::KIND_FLUSH_DONE;
                    out_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ovalid_next = out_load || (ovalid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        home_reg <= home_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
    end

    // Entry memory: one write port, one registered read port. The read address
    // follows the next slot index, so rd_data_reg holds the entry of slot idx_reg.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wr_entry;
        end
        rd_data_reg <= mem[idx_next];
    end

    assign rsp.valid      = ovalid_reg;
    assign rsp.kind       = out_reg.kind;
    assign rsp.hit        = out_reg.hit;
    assign rsp.is_deleted = out_reg.is_deleted;
    assign rsp.out_value  = out_reg.out_value;
    assign rsp.out_object = out_reg.out_object;
    assign rsp.out_attr   = out_reg.out_attr;
    assign rsp.last       = out_reg.last;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten before it was taken");
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FDONE) |-> (used_reg == '0))
        else $error("table not empty at the end of a flush");
    a_hash_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash result arrived outside the hash state");
    a_write_claims: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (used_reg[$past(idx_reg)] && (state_reg == S_IDLE)))
        else $error("entry written without claiming its slot");
    a_flushed_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.kind == wchb_pkg::KIND_FLUSHED)) |-> !rsp.last)
        else $error("flushed entry marked as the final result");
`endif

endmodule
